### rtl/core/sd_spi_host_response_engine_assert.svh
// assertion macros for the sd spi host response engine
`ifndef SD_SPI_HOST_RESPONSE_ENGINE_ASSERT_SVH
`define SD_SPI_HOST_RESPONSE_ENGINE_ASSERT_SVH
// assert that a property holds on every clock edge out of reset
`define SDH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert a condition on the result shown while one is waiting
`define SDH_ASSERT_SHOWN(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !out_empty |-> (cond)) \
    else $error(msg);
`endif

### rtl/core/sdh_pkg.sv
// ----------------------------------------------------------------------------
// sdh_pkg
// types and constants shared by the sd spi host response engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
  typedef enum logic [1:0] {OP_FRAME = 2'd0, OP_PHASE = 2'd1, OP_BYTE = 2'd2,
                            OP_NONE = 2'd3} op_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R1, PH_R1X, PH_EXTRA, PH_BUSY, PH_TOKEN, PH_DATA, PH_CRCHI,
    PH_CRCLO, PH_WRESP
  } phase_t;

  localparam logic [3:0] ST_OK = 4'd0, ST_BUSY_TO = 4'd1, ST_BAD_R1 = 4'd2,
    ST_CMD_TO = 4'd3, ST_RD_TOKEN = 4'd4, ST_RD_TO = 4'd5, ST_RD_CRC = 4'd6,
    ST_WR_CRC = 4'd7, ST_WR_ERR = 4'd8, ST_WR_TOKEN = 4'd9, ST_WR_TO = 4'd10;

  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0, REG_CHECK_CRC = 2'd1,
    REG_READ_TOKEN_LIMIT = 2'd2, REG_WRITE_RESPONSE_LIMIT = 2'd3;

  localparam int FRAME_LEN = 7;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic [7:0]  cmd_check;
    logic [2:0]  phase_select;
    logic [4:0]  extra_count;
    logic [15:0] busy_limit;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       tx_last;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       done_res;
    logic [3:0] status;
  } out_item_t;

  // one classified request passed from the front to the back
  typedef struct packed {
    logic       is_frame;
    logic       is_phase;
    logic       is_byte;
    in_item_t   item;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/core/sdh_front.sv
// ----------------------------------------------------------------------------
// sdh_front
// accepts requests, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sdh_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  output logic                in_full,
  input  sdh_pkg::in_item_t   in_data,
  output logic                q_valid,
  input  wire                 q_take,
  output sdh_pkg::cmd_t       q_cmd
);
  import sdh_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push_ok;
  cmd_t       cls;

  assign in_full = (cnt_r == 3'd4);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 3'd0);
  assign q_cmd   = mem_r[rp_r];

  always_comb begin
    cls.item     = in_data;
    cls.is_frame = (in_data.op == OP_FRAME);
    cls.is_phase = (in_data.op == OP_PHASE) && (in_data.phase_select <= 3'd4);
    cls.is_byte  = (in_data.op == OP_BYTE);
  end

  always_comb begin
    wp_nxt  = wp_r + 2'(push_ok);
    rp_nxt  = rp_r + 2'(q_take);
    cnt_nxt = cnt_r + 3'(push_ok) - 3'(q_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wp_r] <= cls;
    end
  end
endmodule
`default_nettype wire

### rtl/core/sdh_back.sv
// ----------------------------------------------------------------------------
// sdh_back
// runs the response phases and frames commands, one request at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sdh_back #(
  parameter int R1_TRIES  = 8,
  parameter int MAX_BLOCK = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  output logic                q_take,
  input  sdh_pkg::cmd_t       q_cmd,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_idx,
  input  wire  [31:0]         cfg_wdata,
  output logic                out_empty,
  input  wire                 out_pop,
  output sdh_pkg::out_item_t  out_data
);
  import sdh_pkg::*;

  localparam logic [15:0] R1_LIM  = 16'(R1_TRIES);
  localparam logic [12:0] BLK_MAX = 13'(MAX_BLOCK);

  phase_t      ph_r, ph_nxt;
  logic [15:0] poll_r, poll_nxt, lim_r, lim_nxt;
  logic [12:0] left_r, left_nxt;
  logic [15:0] crc_r, crc_nxt, rcrc_r, rcrc_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic [12:0] blen_r;
  logic        chk_r;
  logic [15:0] rtl_r, wrl_r;

  // output buffer of two entries
  out_item_t   ob_r [2];
  logic        owp_r, orp_r;
  logic [1:0]  ocnt_r;
  logic        emit, busy_frame, step;
  out_item_t   res;
  logic [15:0] poll_inc;
  logic [7:0]  rx;
  logic [7:0]  fb;

  assign out_empty = (ocnt_r == 2'd0);
  assign out_data  = ob_r[orp_r];
  // advance only when a result slot is free
  assign step   = q_valid && (ocnt_r != 2'd2 || out_pop);
  assign rx       = q_cmd.item.rx_byte;
  assign poll_inc = poll_r + 16'd1;

  always_comb begin
    unique case (fidx_r)
      3'd0:    fb = 8'hFF;
      3'd1:    fb = {2'b01, q_cmd.item.cmd_index};
      3'd2:    fb = q_cmd.item.cmd_argument[31:24];
      3'd3:    fb = q_cmd.item.cmd_argument[23:16];
      3'd4:    fb = q_cmd.item.cmd_argument[15:8];
      3'd5:    fb = q_cmd.item.cmd_argument[7:0];
      default: fb = q_cmd.item.cmd_check | 8'h01;
    endcase
  end

  always_comb begin
    ph_nxt   = ph_r;
    poll_nxt = poll_r;
    lim_nxt  = lim_r;
    left_nxt = left_r;
    crc_nxt  = crc_r;
    rcrc_nxt = rcrc_r;
    fidx_nxt = fidx_r;
    emit     = 1'b0;
    q_take   = 1'b0;
    res      = '0;
    if (step) begin
      q_take = 1'b1;
      if (q_cmd.is_frame) begin
        emit         = 1'b1;
        res.tx_byte  = fb;
        res.tx_valid = 1'b1;
        res.tx_last  = (fidx_r == 3'(FRAME_LEN - 1));
        if (fidx_r == 3'(FRAME_LEN - 1)) begin
          fidx_nxt = '0;
        end else begin
          fidx_nxt = fidx_r + 3'd1;
          q_take   = 1'b0;
        end
      end else if (q_cmd.is_phase) begin
        poll_nxt = '0;
        left_nxt = '0;
        crc_nxt  = '0;
        rcrc_nxt = '0;
        lim_nxt  = '0;
        unique case (q_cmd.item.phase_select)
          3'd0: ph_nxt = PH_R1;
          3'd1: begin
            ph_nxt   = PH_R1X;
            left_nxt = (q_cmd.item.extra_count > 5'd16) ? 13'd16
                                                         : 13'(q_cmd.item.extra_count);
          end
          3'd2: begin
            ph_nxt  = PH_BUSY;
            lim_nxt = (q_cmd.item.busy_limit == '0) ? 16'd1 : q_cmd.item.busy_limit;
          end
          3'd3: begin
            ph_nxt   = PH_TOKEN;
            lim_nxt  = (rtl_r == '0) ? 16'd1 : rtl_r;
            left_nxt = (blen_r == '0) ? 13'd1 : ((blen_r > BLK_MAX) ? BLK_MAX : blen_r);
          end
          default: begin
            ph_nxt  = PH_WRESP;
            lim_nxt = (wrl_r == '0) ? 16'd1 : wrl_r;
          end
        endcase
      end else if (q_cmd.is_byte) begin
        unique case (ph_r)
          PH_R1, PH_R1X: begin
            if (rx == 8'hFF) begin
              poll_nxt = poll_inc;
              if (poll_inc >= R1_LIM) begin
                ph_nxt = PH_IDLE; emit = 1'b1;
                res.done_res = 1'b1; res.status = ST_CMD_TO;
              end
            end else begin
              emit = 1'b1;
              res.data_byte = rx; res.data_valid = 1'b1;
              if (rx > 8'd1) begin
                ph_nxt = PH_IDLE;
                res.done_res = 1'b1; res.status = ST_BAD_R1;
              end else if (ph_r == PH_R1X && left_r != '0) begin
                ph_nxt = PH_EXTRA;
              end else begin
                ph_nxt = PH_IDLE;
                res.done_res = 1'b1; res.status = ST_OK;
              end
            end
          end
          PH_EXTRA: begin
            emit = 1'b1;
            res.data_byte = rx; res.data_valid = 1'b1;
            if (left_r <= 13'd1) begin
              left_nxt = '0;
              ph_nxt = PH_IDLE; res.done_res = 1'b1;
            end else begin
              left_nxt = left_r - 13'd1;
            end
          end
          PH_BUSY: begin
            if (rx == 8'hFF) begin
              ph_nxt = PH_IDLE; emit = 1'b1; res.done_res = 1'b1;
            end else begin
              poll_nxt = poll_inc;
              if (poll_inc >= lim_r) begin
                ph_nxt = PH_IDLE; emit = 1'b1;
                res.done_res = 1'b1; res.status = ST_BUSY_TO;
              end
            end
          end
          PH_TOKEN: begin
            if (rx == 8'hFF) begin
              poll_nxt = poll_inc;
              if (poll_inc >= lim_r) begin
                ph_nxt = PH_IDLE; emit = 1'b1;
                res.done_res = 1'b1; res.status = ST_RD_TO;
              end
            end else if (rx == 8'hFE) begin
              ph_nxt = PH_DATA; crc_nxt = '0;
            end else begin
              ph_nxt = PH_IDLE; emit = 1'b1;
              res.done_res = 1'b1; res.status = ST_RD_TOKEN;
            end
          end
          PH_DATA: begin
            crc_nxt = crc16_byte(crc_r, rx);
            emit = 1'b1;
            res.data_byte = rx; res.data_valid = 1'b1;
            if (left_r <= 13'd1) begin
              left_nxt = '0; ph_nxt = PH_CRCHI;
            end else begin
              left_nxt = left_r - 13'd1;
            end
          end
          PH_CRCHI: begin
            rcrc_nxt = {rx, 8'h00}; ph_nxt = PH_CRCLO;
          end
          PH_CRCLO: begin
            rcrc_nxt = {rcrc_r[15:8], rx};
            ph_nxt = PH_IDLE; emit = 1'b1; res.done_res = 1'b1;
            if (chk_r && {rcrc_r[15:8], rx} != crc_r) res.status = ST_RD_CRC;
          end
          PH_WRESP: begin
            if (rx == 8'hFF) begin
              poll_nxt = poll_inc;
              if (poll_inc >= lim_r) begin
                ph_nxt = PH_IDLE; emit = 1'b1;
                res.done_res = 1'b1; res.status = ST_WR_TO;
              end
            end else begin
              ph_nxt = PH_IDLE; emit = 1'b1; res.done_res = 1'b1;
              priority case (rx[4:0])
                5'h05:   res.status = ST_OK;
                5'h0B:   res.status = ST_WR_CRC;
                5'h0D:   res.status = ST_WR_ERR;
                default: res.status = ST_WR_TOKEN;
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      poll_r <= '0;
      lim_r  <= '0;
      left_r <= '0;
      crc_r  <= '0;
      rcrc_r <= '0;
      fidx_r <= '0;
      blen_r <= 13'd512;
      chk_r  <= 1'b0;
      rtl_r  <= 16'd100;
      wrl_r  <= 16'd250;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      ph_r   <= ph_nxt;
      poll_r <= poll_nxt;
      lim_r  <= lim_nxt;
      left_r <= left_nxt;
      crc_r  <= crc_nxt;
      rcrc_r <= rcrc_nxt;
      fidx_r <= fidx_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_BLOCK_LENGTH:     blen_r <= cfg_wdata[12:0];
          REG_CHECK_CRC:        chk_r  <= cfg_wdata[0];
          REG_READ_TOKEN_LIMIT: rtl_r  <= cfg_wdata[15:0];
          default:              wrl_r  <= cfg_wdata[15:0];
        endcase
      end
      owp_r  <= owp_r ^ emit;
      orp_r  <= orp_r ^ (out_pop && !out_empty);
      ocnt_r <= ocnt_r + 2'(emit) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r[owp_r] <= res;
    end
  end
endmodule
`default_nettype wire

### rtl/core/sd_spi_host_response_engine.sv
// ----------------------------------------------------------------------------
// sd_spi_host_response_engine
// sd card spi-mode host: command framing and response decoding
// ----------------------------------------------------------------------------
// A request is taken every cycle while in_full is low. The back end takes
// received-byte and phase-start requests one at a time, stalling while the
// two-entry result queue is full; a command frame request stays there until
// all seven frame bytes are written to that queue. A four-entry request
// queue sits between the input and the back end, so input keeps flowing
// while results wait to be popped. Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_host_response_engine #(
  parameter int R1_TRIES  = 8,
  parameter int MAX_BLOCK = 4096
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  output logic                in_full,
  input  sdh_pkg::in_item_t   in_data,
  output logic                out_empty,
  input  wire                 out_pop,
  output sdh_pkg::out_item_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);
  import sdh_pkg::*;

  logic q_valid, q_take;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  sdh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  sdh_back #(.R1_TRIES(R1_TRIES), .MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );
endmodule
`default_nettype wire

### rtl/core/sdh_checker.sv
// ----------------------------------------------------------------------------
// sdh_checker
// port-level checks of the engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_host_response_engine_assert.svh"
module sdh_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_empty,
  input wire                 out_pop,
  input sdh_pkg::out_item_t  out_data
);
  import sdh_pkg::*;

  `SDH_ASSERT_SHOWN(a_last_has_valid, !out_data.tx_last || out_data.tx_valid, "last w/o valid")
  `SDH_ASSERT_SHOWN(a_tx_excl, !out_data.tx_valid || !(out_data.done_res || out_data.data_valid), "mixed")
  `SDH_ASSERT_SHOWN(a_status_range, out_data.status <= ST_WR_TO, "status out of range")
  `SDH_ASSERT(a_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_data), "not held")
endmodule

bind sd_spi_host_response_engine sdh_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_data(out_data)
);
`default_nettype wire
